// File: design/sidec_pkg.sv
// Shared constants and helpers for the signed integer to decimal text unit.
`timescale 1ns / 1ps

package sidec_pkg;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [3:0] DABBLE_LIMIT = 4'd5;
  localparam logic [3:0] DABBLE_ADD   = 4'd3;

  // Correct one BCD digit ahead of a left shift.
  function automatic logic [3:0] dabble_fix(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= DABBLE_LIMIT) ? (d + DABBLE_ADD) : d;
    return r;
  endfunction

endpackage

// File: design/sidec_mag.sv
// Input stage: split the signed value into sign flag and unsigned magnitude.
`timescale 1ns / 1ps

module sidec_mag #(
  parameter int VALUE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  vld_o,
  output logic                  neg_o,
  output logic [VALUE_BITS-1:0] mag_o
);

  logic                  vld_r;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_nxt;
  logic [VALUE_BITS-1:0] mag_nxt;

  // Negating in the full width gives 2^(N-1) for the most negative value.
  assign neg_nxt = value_i[VALUE_BITS-1];
  assign mag_nxt = neg_nxt ? (~value_i + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign vld_o = vld_r;
  assign neg_o = neg_r;
  assign mag_o = mag_r;

endmodule

// File: design/sidec_dabble.sv
// One registered shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps

module sidec_dabble #(
  parameter int VALUE_BITS = 24,
  parameter int NDIG       = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic                  neg_i,
  input  logic [4*NDIG-1:0]     bcd_i,
  input  logic [VALUE_BITS-1:0] bin_i,
  output logic                  vld_o,
  output logic                  neg_o,
  output logic [4*NDIG-1:0]     bcd_o,
  output logic [VALUE_BITS-1:0] bin_o
);

  logic                  vld_r;
  logic                  neg_r;
  logic [4*NDIG-1:0]     bcd_r;
  logic [VALUE_BITS-1:0] bin_r;
  logic [4*NDIG-1:0]     fixed;
  logic [4*NDIG-1:0]     bcd_nxt;
  logic [VALUE_BITS-1:0] bin_nxt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      fixed[4*i +: 4] = sidec_pkg::dabble_fix(bcd_i[4*i +: 4]);
    end
  end

  // Shift the top magnitude bit into the BCD word.
  assign bcd_nxt = {fixed[4*NDIG-2:0], bin_i[VALUE_BITS-1]};
  assign bin_nxt = {bin_i[VALUE_BITS-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= neg_i;
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign vld_o = vld_r;
  assign neg_o = neg_r;
  assign bcd_o = bcd_r;
  assign bin_o = bin_r;

endmodule

// File: design/sidec_serial.sv
// Digit count stage and character emitter with output register.
`timescale 1ns / 1ps

module sidec_serial #(
  parameter int NDIG = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic              neg_i,
  input  logic [4*NDIG-1:0] bcd_i,
  output logic              take_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  localparam int IW = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [IW-1:0] TOP_IDX = IW'(NDIG - 1);

  // count stage
  logic              len_vld_r;
  logic              len_neg_r;
  logic [4*NDIG-1:0] len_bcd_r;
  logic [IW-1:0]     len_top_r;
  logic [IW-1:0]     len_top_nxt;
  logic              len_en;

  // emitter
  logic              busy_r;
  logic              sign_r;
  logic [4*NDIG-1:0] bcd_r;
  logic [IW-1:0]     idx_r;
  logic              out_free;
  logic              emit;
  logic              emit_last;
  logic              load;
  logic [3:0]        digit;
  logic [7:0]        char_nxt;

  logic              out_vld_r;
  logic [7:0]        out_char_r;
  logic              out_last_r;

  always_comb begin
    len_top_nxt = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_i[4*i +: 4] != 4'd0) begin
        len_top_nxt = IW'(i);
      end
    end
  end

  assign out_free  = !out_vld_r || out_tready;
  assign emit      = busy_r && out_free;
  assign emit_last = emit && !sign_r && (idx_r == '0);
  assign load      = len_vld_r && (!busy_r || emit_last);
  assign len_en    = !len_vld_r || load;
  assign take_o    = len_en;

  assign digit    = bcd_r[4*idx_r +: 4];
  assign char_nxt = sign_r ? sidec_pkg::CH_MINUS : (sidec_pkg::CH_ZERO + {4'd0, digit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= 1'b0;
    end else if (len_en) begin
      len_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (len_en) begin
      len_neg_r <= neg_i;
      len_bcd_r <= bcd_i;
      len_top_r <= len_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
      sign_r <= len_neg_r;
    end else if (emit_last) begin
      busy_r <= 1'b0;
    end else if (emit) begin
      sign_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= len_bcd_r;
      idx_r <= len_top_r;
    end else if (emit && !sign_r) begin
      idx_r <= idx_r - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= !sign_r && (idx_r == '0);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_char_r == sidec_pkg::CH_MINUS) |-> !out_last_r)
    else $error("minus sign marked as last character");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= TOP_IDX))
    else $error("digit index out of range");
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_vld_r |-> (len_top_r <= TOP_IDX))
    else $error("digit count out of range");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !out_tready) |=> !(out_vld_r && !$past(out_vld_r)))
    else $error("character emitted while emitter idle");
`endif

endmodule

// File: design/signed_int_to_decimal_ascii_unit.sv
// Top level: signed integer to decimal ASCII text, one character per transaction.
`timescale 1ns / 1ps
// Throughput: one character per cycle while out_tready is high, set by the single
//   character output register; an item holds the emitter for all its characters (1 to 8 at 24 bits).
// The conversion pipeline (sign stage, VALUE_BITS double-dabble stages, count stage)
//   accepts an item every cycle while the emitter keeps up.
// Reset (rst_n low, synchronous) clears all valid bits and holds in_tready low.

module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] in_tdata,   // [VALUE_BITS-1:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] character
  output logic                                out_tlast
);

  // Digits needed for the largest magnitude 2^(VALUE_BITS-1); log10(2) ~ 0.30103.
  localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

  logic                  en;
  logic                  mag_vld;
  logic                  mag_neg;
  logic [VALUE_BITS-1:0] mag;

  // Chain taps: index 0 feeds the first dabble step.
  logic                  vld_w [0:VALUE_BITS];
  logic                  neg_w [0:VALUE_BITS];
  logic [4*NDIG-1:0]     bcd_w [0:VALUE_BITS];
  logic [VALUE_BITS-1:0] bin_w [0:VALUE_BITS];

  // The whole conversion pipeline advances together; it stalls only when the
  // count stage at its end is full and cannot hand off to the emitter.
  // Hold ready low in reset so no transaction is taken and dropped there.
  assign in_tready = en && rst_n;

  sidec_mag #(.VALUE_BITS(VALUE_BITS)) u_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_tvalid),
    .value_i (in_tdata[VALUE_BITS-1:0]),
    .vld_o   (mag_vld),
    .neg_o   (mag_neg),
    .mag_o   (mag)
  );

  assign vld_w[0] = mag_vld;
  assign neg_w[0] = mag_neg;
  assign bcd_w[0] = '0;
  assign bin_w[0] = mag;

  // One stage per magnitude bit, most significant bit first.
  for (genvar g = 0; g < VALUE_BITS; g++) begin : g_dabble
    sidec_dabble #(.VALUE_BITS(VALUE_BITS), .NDIG(NDIG)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_w[g]),
      .neg_i (neg_w[g]),
      .bcd_i (bcd_w[g]),
      .bin_i (bin_w[g]),
      .vld_o (vld_w[g+1]),
      .neg_o (neg_w[g+1]),
      .bcd_o (bcd_w[g+1]),
      .bin_o (bin_w[g+1])
    );
  end

  // Count significant digits, then emit sign and digits with tlast on the final one.
  sidec_serial #(.NDIG(NDIG)) u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld_w[VALUE_BITS]),
    .neg_i      (neg_w[VALUE_BITS]),
    .bcd_i      (bcd_w[VALUE_BITS]),
    .take_o     (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: test/tb_signed_int_to_decimal_ascii_unit.sv
// Testbench for the signed integer to decimal ASCII unit: directed table, random values, scoreboard.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;

  localparam int VALUE_BITS    = 24;
  localparam int DATA_BITS     = ((VALUE_BITS + 7) / 8) * 8;
  localparam int NUM_DIRECTED  = 22;
  localparam int NUM_RANDOM    = 188;
  // Cycles without any transaction before the run is declared hung. Covers the
  // longest sink stall times eight characters plus pipeline latency, many times over.
  localparam int IDLE_LIMIT    = 5000;
  // Drain time after the last character: pipeline latency plus margin.
  localparam int DRAIN_CYCLES  = VALUE_BITS + 3 + 20;
  localparam int SIGN_MAX      = 8388607;

  // One character of decimal text as it should leave the block.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_BITS-1:0] in_tdata   = '0;   // [23:0] value
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // [7:0] character
  logic                 out_tlast;

  text_char_t pending_chars[$];   // characters still owed by the block, oldest first
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  bit         calm           = 1'b0;   // suppress idling on both sides
  int         sink_stall     = 0;

  // Directed table: value and, where obvious, the exact text. An empty text
  // means the row is checked against the text predictor.
  int    dir_value [NUM_DIRECTED] = '{
    0, 1, -1, 9, 10, -10, 99, 100, -100,
    8388607, -8388607, -8388608,
    1000000, -999999, 1234567, -7654321,
    4194304, -4194304, 65535, -65536,
    5592405, -5592406
  };
  string dir_text  [NUM_DIRECTED] = '{
    "0", "1", "-1", "", "", "", "", "", "",
    "8388607", "-8388607", "-8388608",
    "", "", "", "", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Queue the decimal text of a value: sign, then digits from the most
  // significant, no leading zeros, last flag on the final digit.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
    logic              negative;
    logic [VALUE_BITS-1:0] magnitude;
    int unsigned       rest;
    logic [7:0]        digits[8];
    int                num_digits;
    text_char_t        c;
    negative   = value[VALUE_BITS-1];
    // Unsigned magnitude: the most negative value becomes 2^(VALUE_BITS-1).
    magnitude  = negative ? (~value + 1'b1) : value;
    rest       = 32'(magnitude);
    num_digits = 0;
    if (rest == 0) begin
      digits[0]  = sidec_pkg::CH_ZERO;
      num_digits = 1;
    end
    while (rest != 0) begin
      digits[num_digits] = sidec_pkg::CH_ZERO + 8'(rest % 10);
      num_digits++;
      rest = rest / 10;
    end
    if (negative) begin
      c.character = sidec_pkg::CH_MINUS;
      c.last      = 1'b0;
      pending_chars.push_back(c);
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      c.character = digits[k];
      c.last      = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // Queue a literal string of expected characters.
  function automatic void expect_string(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.character = text[i];
      c.last      = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Random value: full-range words, magnitudes of random digit count, and
  // values sitting on a power of ten or the ends of the range.
  function automatic logic [VALUE_BITS-1:0] random_value();
    int          r;
    int          num_digits;
    int unsigned scale;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 4) return VALUE_BITS'($urandom());
    scale = 1;
    num_digits = $urandom_range(1, 7);
    repeat (num_digits) scale = scale * 10;
    if (r < 8) begin
      v = $urandom_range(0, scale - 1);
    end else if (r == 8) begin
      // Land on or next to a power of ten.
      v = scale / 10 + $urandom_range(0, 2) - 1;
      if (v < 0) v = 0;
    end else begin
      v = $urandom_range(SIGN_MAX - 3, SIGN_MAX);
    end
    if (v > SIGN_MAX) v = SIGN_MAX;
    if ($urandom_range(0, 1)) begin
      v = -v;
      // Reach the most negative value from the top of the range now and then.
      if (r == 9 && v == -SIGN_MAX && $urandom_range(0, 1)) v = v - 1;
    end
    return VALUE_BITS'(v);
  endfunction

  // Offer one value, hold it until accepted, then queue its text.
  // Enter and leave at a rising edge.
  task automatic send_value(input logic [VALUE_BITS-1:0] value, input string text);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_BITS'(value);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (text.len() == 0) predict_text(value);
    else expect_string(text);
  endtask

  // Result sink: stall out_tready at random, except in calm stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall =  0;
    end else if (sink_stall > 0) begin
      out_tready <= 1'b0;
      sink_stall =  sink_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
    end
  end

  // Scoreboard: compare each character transaction with the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character transaction: character=%0d last=%0b",
               out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.character) begin
          $error("character mismatch: expected %0d, got %0d", want.character, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transaction for %0d cycles, %0d characters outstanding",
               IDLE_LIMIT, pending_chars.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, single digits, powers of ten, range ends, bit patterns.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_value(VALUE_BITS'(dir_value[i]), dir_text[i]);
    end

    // Random: a calm stretch with no idling, and one pause until all text is out.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 60 && i < 100);
      if (i == 130) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
      end
      send_value(random_value(), "");
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then give any stray characters time to show up.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
